// ----- hw/rtl/hct_pkg.sv -----
// shared types, constants and hash function for the hashed challenge table
package hct_pkg;

    localparam int BUCKETS  = 1024;
    localparam int WAYS     = 8;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = $clog2(WAYS);

    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_HASH_BASE = 1'b0;

    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    localparam logic [31:0] CHAL_EMPTY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [WAYS-1:0][31:0] addr;
        logic [WAYS-1:0][31:0] chal;
        logic [WAY_W-1:0]      ptr;
    } row_t;

    localparam row_t ROW_RESET = '{addr: '0, chal: {WAYS{CHAL_EMPTY}}, ptr: '0};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

    function automatic logic [BUCKET_W-1:0] bucket_of(logic [31:0] ip, logic [31:0] base);
        logic [31:0] s;
        logic [31:0] h;
        s = ip + base;
        h = (s ^ (s << 16)) | (s >> 16);
        return BUCKET_W'(h % BUCKETS);
    endfunction

endpackage

// ----- hw/rtl/hct_req_if.sv -----
// request channel: valid/ready handshake with the lookup fields
interface hct_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] sender_address;
    logic [31:0] offered_challenge;
    logic [30:0] fresh_challenge;

    modport source (
        output valid, operation, sender_address, offered_challenge, fresh_challenge,
        input  ready
    );
    modport sink (
        input  valid, operation, sender_address, offered_challenge, fresh_challenge,
        output ready
    );
endinterface

// ----- hw/rtl/hct_rsp_if.sv -----
// response channel: valid/ready handshake with the result fields
interface hct_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] challenge_value;
    logic        accepted;
    logic        was_present;

    modport source (
        output valid, challenge_value, accepted, was_present,
        input  ready
    );
    modport sink (
        input  valid, challenge_value, accepted, was_present,
        output ready
    );
endinterface

// ----- hw/rtl/hct_ctrl.sv -----
// controller state machine: clearing pass, accept, row commit and output valid
module hct_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  hct_pkg::sts_t sts,
    output hct_pkg::cmd_t cmd
);

    hct_pkg::state_t state_reg;
    hct_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hct_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            hct_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = hct_pkg::ST_IDLE;
                end
            end
            hct_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = hct_pkg::ST_LOOKUP;
                end
            end
            hct_pkg::ST_LOOKUP:
            begin
                // row is held until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = hct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hct_pkg::ST_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ----- hw/rtl/hct_dp.sv -----
// datapath: bucket row memory, hash, way search, row update and result register
module hct_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   hash_base,
    input  logic          operation,
    input  logic [31:0]   sender_address,
    input  logic [31:0]   offered_challenge,
    input  logic [30:0]   fresh_challenge,
    input  hct_pkg::cmd_t cmd,
    output hct_pkg::sts_t sts,
    output logic [31:0]   challenge_value,
    output logic          accepted,
    output logic          was_present
);

    hct_pkg::row_t row_mem [hct_pkg::BUCKETS];

    hct_pkg::row_t                   rd_row_reg;
    logic                            op_reg;
    logic [31:0]                     ip_reg;
    logic [31:0]                     offered_reg;
    logic [30:0]                     fresh_reg;
    logic [hct_pkg::BUCKET_W-1:0]    bucket_reg;
    logic [hct_pkg::BUCKET_W-1:0]    clr_cnt_reg;
    logic [31:0]                     value_reg;
    logic                            acc_reg;
    logic                            present_reg;

    logic [hct_pkg::BUCKET_W-1:0]    bucket_next;
    logic                            hit;
    logic [hct_pkg::WAY_W-1:0]       hit_way;
    logic [31:0]                     hit_chal;
    hct_pkg::row_t                   new_row;
    logic [31:0]                     value_next;
    logic                            acc_next;
    logic                            wr_en;

    assign bucket_next = hct_pkg::bucket_of(sender_address, hash_base);

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == hct_pkg::BUCKET_W'(hct_pkg::BUCKETS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            row_mem[clr_cnt_reg] <= hct_pkg::ROW_RESET;
        end
        else if (wr_en)
        begin
            row_mem[bucket_reg] <= new_row;
        end
        if (cmd.load)
        begin
            rd_row_reg <= row_mem[bucket_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            ip_reg      <= sender_address;
            offered_reg <= offered_challenge;
            fresh_reg   <= fresh_challenge;
            bucket_reg  <= bucket_next;
        end
        if (cmd.commit)
        begin
            value_reg   <= value_next;
            acc_reg     <= acc_next;
            present_reg <= hit;
        end
    end

    // first matching way, lowest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int j = hct_pkg::WAYS - 1; j >= 0; j--)
        begin
            if (rd_row_reg.addr[j] == ip_reg)
            begin
                hit     = 1'b1;
                hit_way = hct_pkg::WAY_W'(j);
            end
        end
    end

    assign hit_chal = rd_row_reg.chal[hit_way];

    // hit moves the entry to the newest slot, miss replaces the oldest
    always_comb
    begin
        logic [hct_pkg::WAY_W-1:0] last;
        logic [hct_pkg::WAY_W-1:0] dl;
        logic [hct_pkg::WAY_W-1:0] dj;
        logic [hct_pkg::WAY_W-1:0] nxt;
        new_row = rd_row_reg;
        last    = rd_row_reg.ptr - 1'b1;
        dl      = last - hit_way;
        dj      = '0;
        nxt     = '0;
        if (hit)
        begin
            for (int j = 0; j < hct_pkg::WAYS; j++)
            begin
                dj  = hct_pkg::WAY_W'(j) - hit_way;
                nxt = hct_pkg::WAY_W'(j) + 1'b1;
                if (dj < dl)
                begin
                    new_row.addr[j] = rd_row_reg.addr[nxt];
                    new_row.chal[j] = rd_row_reg.chal[nxt];
                end
                else if (dj == dl)
                begin
                    new_row.addr[j] = ip_reg;
                    new_row.chal[j] = hit_chal;
                end
            end
        end
        else
        begin
            new_row.addr[rd_row_reg.ptr] = ip_reg;
            new_row.chal[rd_row_reg.ptr] = {1'b0, fresh_reg};
            new_row.ptr                  = rd_row_reg.ptr + 1'b1;
        end
    end

    always_comb
    begin
        if (op_reg == hct_pkg::OP_ASSIGN)
        begin
            value_next = hit ? hit_chal : {1'b0, fresh_reg};
            acc_next   = 1'b0;
        end
        else
        begin
            value_next = '0;
            acc_next   = !offered_reg[31] && hit && (hit_chal == offered_reg);
        end
    end

    assign wr_en = cmd.commit && (op_reg == hct_pkg::OP_ASSIGN);

    assign challenge_value = value_reg;
    assign accepted        = acc_reg;
    assign was_present     = present_reg;

endmodule

// ----- hw/rtl/hashed_challenge_table_unit.sv -----
// top level: register port, controller and datapath of the hashed challenge table
// Each request is taken in the accept cycle, which reads the request's bucket row
// from the row memory; in the lookup state the unit then searches the ways, writes
// the updated row back for an assign and loads the output register; a stalled output
// holds the item in the lookup state. After reset a clearing pass writes all 1024
// bucket rows, one per cycle, during which no request is taken; register writes are
// taken at any time.
module hashed_challenge_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hct_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    hct_req_if.sink                        req,
    hct_rsp_if.source                      rsp
);

    logic [31:0]                    hash_base_reg;
    logic [hct_pkg::REG_IDX_W-1:0]  reg_idx;
    hct_pkg::cmd_t                  cmd;
    hct_pkg::sts_t                  sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hct_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_base_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == hct_pkg::REG_HASH_BASE))
        begin
            hash_base_reg <= pwdata;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hct_pkg::REG_HASH_BASE: prdata = hash_base_reg;
            default:                prdata = '0;
        endcase
    end

    hct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hct_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .hash_base         (hash_base_reg),
        .operation         (req.operation),
        .sender_address    (req.sender_address),
        .offered_challenge (req.offered_challenge),
        .fresh_challenge   (req.fresh_challenge),
        .cmd               (cmd),
        .sts               (sts),
        .challenge_value   (rsp.challenge_value),
        .accepted          (rsp.accepted),
        .was_present       (rsp.was_present)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    // an accepted verify returns no challenge and implies a hit
    a_verify_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> (rsp.challenge_value == '0) && rsp.was_present)
        else $error("accepted verify with bad result fields");

    // a fresh challenge never has its top bit set
    a_fresh_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.challenge_value[31] |-> rsp.was_present)
        else $error("missed assign returned a challenge with top bit set");

    // no request is taken during the clearing pass
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !req.ready)
        else $error("request ready during clearing pass");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench for the hashed challenge table unit: directed and random lookups against a table model
module tb;
    import hct_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int RUN_LIMIT    = 200000;
    localparam int HOT_BUCKETS  = 4;
    localparam int POOL_SIZE    = 48;
    localparam int PHASE_ITEMS  = 300;
    localparam logic [APB_ADDR_W-1:0] HASH_BASE_ADDR = APB_ADDR_W'({REG_HASH_BASE, 2'b00});

    typedef struct packed {
        logic [31:0] value;
        logic        accepted;
        logic        present;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    hct_req_if req_ch ();
    hct_rsp_if rsp_ch ();

    hashed_challenge_table_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // table model
    logic [31:0] tbl_addr [BUCKETS*WAYS];
    logic [31:0] tbl_chal [BUCKETS*WAYS];
    int unsigned tbl_oldest [BUCKETS];
    logic [31:0] hash_base_model;

    reply_t pending_replies [$];

    int failures;
    int cycles;
    int n_sent;
    int n_hits;
    int n_misses;
    int n_accepts;
    int n_top_rejects;
    int n_bases;

    bit offering;
    bit gaps_on;
    int burst_left;
    int hold_request;
    int hold_left;
    int rsp_style;
    int style_left;
    int rsp_phase;

    logic [31:0] addr_pool [POOL_SIZE];

    always #1 clk = ~clk;

    function automatic int unsigned bucket_for(logic [31:0] ip);
        logic [31:0] s;
        logic [31:0] h;
        s = ip + hash_base_model;
        h = (s ^ (s << 16)) | (s >> 16);
        return h % BUCKETS;
    endfunction

    function automatic int unsigned first_way(int unsigned b, logic [31:0] ip);
        int unsigned w;
        for (w = 0; w < WAYS; w++)
        begin
            if (tbl_addr[b*WAYS + w] == ip)
                return w;
        end
        return WAYS;
    endfunction

    function automatic reply_t apply_to_table(logic op, logic [31:0] ip, logic [31:0] offered,
                                              logic [30:0] fresh);
        int unsigned b;
        int unsigned base;
        int unsigned p;
        int unsigned w;
        int unsigned last;
        int unsigned cur;
        int unsigned nxt;
        reply_t r;
        b = bucket_for(ip);
        base = b * WAYS;
        p = tbl_oldest[b] % WAYS;
        w = first_way(b, ip);
        r = '0;
        r.present = (w < WAYS);
        if (op == OP_ASSIGN)
        begin
            if (r.present)
            begin
                // hit: rotate the entry to the newest slot
                last = (p + WAYS - 1) % WAYS;
                r.value = tbl_chal[base + w];
                cur = w;
                while (cur != last)
                begin
                    nxt = (cur + 1) % WAYS;
                    tbl_addr[base + cur] = tbl_addr[base + nxt];
                    tbl_chal[base + cur] = tbl_chal[base + nxt];
                    cur = nxt;
                end
                tbl_addr[base + last] = ip;
                tbl_chal[base + last] = r.value;
                n_hits++;
            end
            else
            begin
                r.value = {1'b0, fresh};
                tbl_addr[base + p] = ip;
                tbl_chal[base + p] = {1'b0, fresh};
                tbl_oldest[b] = (p + 1) % WAYS;
                n_misses++;
            end
        end
        else
        begin
            if (offered[31])
                n_top_rejects++;
            else if (r.present && tbl_chal[base + w] == offered)
            begin
                r.accepted = 1'b1;
                n_accepts++;
            end
        end
        return r;
    endfunction

    // address whose hash lands in bucket b under the current base
    function automatic logic [31:0] address_in_bucket(int unsigned b);
        logic [31:0] s;
        s = $urandom;
        s[BUCKET_W-1:0] = b[BUCKET_W-1:0];
        s[16 +: BUCKET_W] = '0;
        return s - hash_base_model;
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    // reply checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
                note_failure($sformatf("unexpected reply: value %h accepted %b present %b",
                                       rsp_ch.challenge_value, rsp_ch.accepted,
                                       rsp_ch.was_present));
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.challenge_value !== want.value || rsp_ch.accepted !== want.accepted
                    || rsp_ch.was_present !== want.present)
                    note_failure($sformatf(
                        "reply mismatch: expected value %h accepted %b present %b, got %h %b %b",
                        want.value, want.accepted, want.present, rsp_ch.challenge_value,
                        rsp_ch.accepted, rsp_ch.was_present));
            end
        end
    end

    // reply side stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (style_left == 0)
        begin
            rsp_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 120);
        end
        style_left--;
        rsp_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (rsp_style)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                2: rsp_ch.ready <= (rsp_phase % 3 == 0);
                default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(logic op, logic [31:0] ip, logic [31:0] offered,
                                logic [30:0] fresh);
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.sender_address <= ip;
        req_ch.offered_challenge <= offered;
        req_ch.fresh_challenge <= fresh;
        offering = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_replies.push_back(apply_to_table(op, ip, offered, fresh));
        n_sent++;
        if (burst_left > 0)
            burst_left--;
        else if (gaps_on)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic wait_idle();
        if (offering)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic refresh_address_pool();
        int unsigned hot;
        int i;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            if (i % (POOL_SIZE / HOT_BUCKETS) == 0)
                hot = $urandom_range(0, BUCKETS - 1);
            addr_pool[i] = address_in_bucket(hot);
        end
        addr_pool[POOL_SIZE-1] = '0;
    endtask

    task automatic set_hash_base(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HASH_BASE_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        hash_base_model = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            note_failure($sformatf("hash base readback: expected %h, got %h", value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        n_bases++;
        refresh_address_pool();
    endtask

    task automatic random_request(bit noise);
        logic        op;
        logic [31:0] ip;
        logic [31:0] offered;
        logic [30:0] fresh;
        int unsigned b;
        int unsigned w;
        int          pick;
        fresh = 31'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            fresh = '0;
        else if (pick == 1)
            fresh = '1;
        if (noise || $urandom_range(0, 99) < 15)
        begin
            op = 1'($urandom);
            ip = $urandom;
            offered = $urandom;
        end
        else
        begin
            ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            op = ($urandom_range(0, 1) == 0) ? OP_ASSIGN : OP_VERIFY;
            b = bucket_for(ip);
            w = first_way(b, ip);
            pick = $urandom_range(0, 9);
            if (w < WAYS && pick < 6)
                offered = tbl_chal[b*WAYS + w];
            else if (pick < 8)
                offered = $urandom & 32'h7FFF_FFFF;
            else
                offered = $urandom | 32'h8000_0000;
        end
        send_request(op, ip, offered, fresh);
    endtask

    task automatic test_empty_slots_and_eviction();
        logic [31:0] ring [9];
        int i;
        set_hash_base('0);
        // unwritten slots hold address zero
        send_request(OP_ASSIGN, '0, '0, 31'h1234);
        send_request(OP_VERIFY, '0, CHAL_EMPTY, '0);
        for (i = 0; i < 9; i++)
            ring[i] = address_in_bucket(5);
        send_request(OP_ASSIGN, ring[0], '0, 31'h7FFF_FFFF);
        send_request(OP_VERIFY, ring[0], 32'h7FFF_FFFF, '0);
        send_request(OP_VERIFY, ring[0], 32'hFFFF_FFFF, '0);
        send_request(OP_VERIFY, ring[0], 32'h7FFF_FFFE, '0);
        send_request(OP_VERIFY, address_in_bucket(5), $urandom, '1);
        for (i = 1; i < 8; i++)
            send_request(OP_ASSIGN, ring[i], $urandom, (i == 1) ? 31'h0 : 31'($urandom));
        // newest hit, oldest hit, then eviction of the oldest
        send_request(OP_ASSIGN, ring[7], '0, '0);
        send_request(OP_ASSIGN, ring[0], '0, '0);
        send_request(OP_ASSIGN, ring[8], '0, 31'($urandom));
        send_request(OP_VERIFY, ring[1], '0, '0);
        send_request(OP_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'($urandom));
        send_request(OP_VERIFY, 32'hFFFF_FFFF, '0, '0);
        wait_idle();
    endtask

    task automatic test_hash_base_sweep();
        logic [31:0] bases [5];
        int p;
        int i;
        bases[0] = 32'hFFFF_FFFF;
        bases[1] = 32'h8000_0000;
        bases[2] = $urandom;
        bases[3] = $urandom;
        bases[4] = '0;
        for (p = 0; p < 5; p++)
        begin
            set_hash_base(bases[p]);
            gaps_on = (p != 2);
            for (i = 0; i < PHASE_ITEMS; i++)
                random_request(1'b0);
            wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        int r;
        int i;
        for (r = 0; r < 2; r++)
        begin
            gaps_on = 1'b0;
            hold_request = 300;
            for (i = 0; i < 60; i++)
                random_request(1'b0);
            wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_unformed_traffic();
        int i;
        set_hash_base($urandom);
        for (i = 0; i < 300; i++)
            random_request(1'b1);
        wait_idle();
    endtask

    initial
    begin
        int k;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_ASSIGN;
        req_ch.sender_address = '0;
        req_ch.offered_challenge = '0;
        req_ch.fresh_challenge = '0;
        rsp_ch.ready = 1'b0;
        gaps_on = 1'b1;
        for (k = 0; k < BUCKETS*WAYS; k++)
        begin
            tbl_addr[k] = '0;
            tbl_chal[k] = CHAL_EMPTY;
        end
        for (k = 0; k < BUCKETS; k++)
            tbl_oldest[k] = 0;
        hash_base_model = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_slots_and_eviction();
        test_hash_base_sweep();
        test_output_stall();
        test_unformed_traffic();
        repeat (20) @(posedge clk);
        $display("covered %0d requests under %0d hash base settings: %0d assign hits, %0d misses",
                 n_sent, n_bases, n_hits, n_misses);
        $display("verify: %0d accepted, %0d offers with the top bit set; %0d failures",
                 n_accepts, n_top_rejects, failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- hashed_challenge_table_unit.f -----
hw/rtl/hct_pkg.sv
hw/rtl/hct_req_if.sv
hw/rtl/hct_rsp_if.sv
hw/rtl/hct_ctrl.sv
hw/rtl/hct_dp.sv
hw/rtl/hashed_challenge_table_unit.sv
dv/tb.sv
